[design/lep_pkg.sv]
package lep_pkg;

    // Pipeline shape.
    localparam int DIV_STAGES   = 14;
    localparam int SHADE_STAGES = 4;
    localparam int PHASE_SPS    = 4;
    localparam int HUE_SPS      = 2;
    localparam int MOD_SPS      = 1;

    // Effect codes.
    localparam logic [2:0] MODE_OFF      = 3'd0;
    localparam logic [2:0] MODE_SOLID    = 3'd1;
    localparam logic [2:0] MODE_SNAKE    = 3'd2;
    localparam logic [2:0] MODE_RAINBOW  = 3'd3;
    localparam logic [2:0] MODE_BREATH   = 3'd4;
    localparam logic [2:0] MODE_GRADIENT = 3'd5;
    localparam logic [2:0] MODE_SHALLOW  = 3'd6;

    // Register indexes.
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_COLOR  = 3'd1;
    localparam logic [2:0] REG_BRIGHT = 3'd2;
    localparam logic [2:0] REG_SPEED  = 3'd3;
    localparam logic [2:0] REG_ZONE   = 3'd4;

    localparam logic [11:0] PERIOD_SLOW = 12'd4000;
    localparam logic [7:0]  LEVEL_FULL  = 8'd255;

    typedef struct packed {
        logic [2:0]  mode;
        logic [23:0] base;
        logic [7:0]  bright;
        logic        speed_zero;
        logic        n_is_one;
        logic [11:0] period;
    } lep_cfg_t;

    // Exact floor(x / 255) for x up to 65152.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    function automatic logic [7:0] tri_wave(input logic [7:0] p);
        logic [8:0] v;
        logic [9:0] v2;
        v  = 9'd256 - {1'b0, p};
        v2 = {v, 1'b0};
        if (p < 8'd128)
        begin
            return {p[6:0], 1'b0};
        end
        return (v2 > 10'd255) ? 8'd255 : v2[7:0];
    endfunction

endpackage

[design/lep_if.sv]
interface lep_pix_if;
    logic        valid;
    logic        ready;
    logic [47:0] time_ms;
    logic [7:0]  position;
    logic [7:0]  led_index;
    logic        enable;

    modport source (output valid, time_ms, position, led_index, enable, input ready);
    modport sink (input valid, time_ms, position, led_index, enable, output ready);
endinterface

interface lep_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] led_index_out;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, led_index_out, red, green, blue, input ready);
    modport sink (input valid, led_index_out, red, green, blue, output ready);
endinterface

interface lep_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/lep_cfg.sv]
module lep_cfg
    import lep_pkg::*;
#(
    parameter int MAX_PIXELS = 256,
    parameter int NW         = 9
)
(
    input  logic         clk,
    input  logic         rst_n,
    lep_cfg_if.sink      cfg,
    output lep_cfg_t     zone_cfg,
    output logic [NW-1:0] n,
    output logic [NW-1:0] n_minus1
);

    logic [2:0]    mode_reg;
    logic [23:0]   base_reg;
    logic [7:0]    bright_reg;
    logic          speed_zero_reg;
    logic          n_is_one_reg;
    logic [11:0]   period_reg;
    logic [NW-1:0] n_reg;
    logic [NW-1:0] n_minus1_reg;

    logic [11:0]   period_next;
    logic [NW-1:0] n_next;
    logic [15:0]   frac_x;
    logic [8:0]    zone_in;

    // Period = 4000 - round(3000*s/255), split as 11*s + (195*s+127)/255.
    always_comb
    begin
        frac_x      = 16'(cfg.data[7:0]) * 16'd195 + 16'd127;
        period_next = PERIOD_SLOW - (12'(cfg.data[7:0]) * 12'd11 + 12'(div255(frac_x)));
        zone_in     = cfg.data[8:0];
        if (zone_in == 9'd0)
        begin
            n_next = NW'(1);
        end
        else if (32'(zone_in) > MAX_PIXELS)
        begin
            n_next = NW'(MAX_PIXELS);
        end
        else
        begin
            n_next = NW'(zone_in);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_OFF;
            base_reg       <= '0;
            bright_reg     <= LEVEL_FULL;
            speed_zero_reg <= 1'b1;
            period_reg     <= PERIOD_SLOW;
            n_reg          <= NW'(1);
            n_minus1_reg   <= '0;
            n_is_one_reg   <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MODE:   mode_reg <= cfg.data[2:0];
                REG_COLOR:  base_reg <= cfg.data;
                REG_BRIGHT: bright_reg <= cfg.data[7:0];
                REG_SPEED:
                begin
                    speed_zero_reg <= (cfg.data[7:0] == 8'd0);
                    period_reg     <= period_next;
                end
                REG_ZONE:
                begin
                    n_reg        <= n_next;
                    n_minus1_reg <= n_next - NW'(1);
                    n_is_one_reg <= (n_next == NW'(1));
                end
                default: ;
            endcase
        end
    end

    assign cfg.ready           = 1'b1;
    assign zone_cfg.mode       = mode_reg;
    assign zone_cfg.base       = base_reg;
    assign zone_cfg.bright     = bright_reg;
    assign zone_cfg.speed_zero = speed_zero_reg;
    assign zone_cfg.n_is_one   = n_is_one_reg;
    assign zone_cfg.period     = period_reg;
    assign n                   = n_reg;
    assign n_minus1            = n_minus1_reg;

endmodule

[design/lep_div.sv]
module lep_div
#(
    parameter int STAGES = 14,
    parameter int SPS    = 4,
    parameter int DVW    = 12,
    parameter int QW     = 8
)
(
    input  logic                    clk,
    input  logic [STAGES-1:0]       load,
    input  logic [STAGES*SPS-1:0]   dividend,
    input  logic [DVW-1:0]          divisor,
    output logic [QW-1:0]           quotient,
    output logic [DVW-1:0]          remainder
);

    localparam int DDW = STAGES * SPS;

    logic [DDW-1:0] dvd_reg [STAGES];
    logic [DVW-1:0] rem_reg [STAGES];
    logic [QW-1:0]  quo_reg [STAGES];
    logic [DDW-1:0] dvd_next [STAGES];
    logic [DVW-1:0] rem_next [STAGES];
    logic [QW-1:0]  quo_next [STAGES];
    logic [DDW-1:0] dvd_src [STAGES];
    logic [DVW-1:0] rem_src [STAGES];
    logic [QW-1:0]  quo_src [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            if (s == 0)
            begin : g_first
                assign dvd_src[s] = dividend;
                assign rem_src[s] = '0;
                assign quo_src[s] = '0;
            end
            else
            begin : g_rest
                assign dvd_src[s] = dvd_reg[s-1];
                assign rem_src[s] = rem_reg[s-1];
                assign quo_src[s] = quo_reg[s-1];
            end

            // Restoring division, SPS dividend bits per stage.
            always_comb
            begin
                logic [DDW-1:0] d;
                logic [DVW:0]   r;
                logic [DVW-1:0] m;
                logic [QW-1:0]  q;
                d = dvd_src[s];
                m = rem_src[s];
                q = quo_src[s];
                for (int k = 0; k < SPS; k++)
                begin
                    r = {m, d[DDW-1]};
                    d = d << 1;
                    if (r >= {1'b0, divisor})
                    begin
                        r = r - {1'b0, divisor};
                        q = (q << 1) | QW'(1);
                    end
                    else
                    begin
                        q = q << 1;
                    end
                    m = r[DVW-1:0];
                end
                dvd_next[s] = d;
                rem_next[s] = m;
                quo_next[s] = q;
            end

            always_ff @(posedge clk)
            begin
                if (load[s])
                begin
                    dvd_reg[s] <= dvd_next[s];
                    rem_reg[s] <= rem_next[s];
                    quo_reg[s] <= quo_next[s];
                end
            end
        end
    endgenerate

    assign quotient  = quo_reg[STAGES-1];
    assign remainder = rem_reg[STAGES-1];

endmodule

[design/lep_shade.sv]
module lep_shade
    import lep_pkg::*;
#(
    parameter int NW = 9
)
(
    input  logic                    clk,
    input  logic [SHADE_STAGES-1:0] load,
    input  lep_cfg_t                zone_cfg,
    input  logic [NW-1:0]           n,
    input  logic [7:0]              ph_raw,
    input  logic [7:0]              hue_off,
    input  logic [7:0]              grad_off,
    input  logic [NW-1:0]           pmod,
    input  logic [7:0]              idx,
    input  logic                    black,
    output logic [7:0]              led_index_out,
    output logic [7:0]              red,
    output logic [7:0]              green,
    output logic [7:0]              blue
);

    // First stage: phase-derived terms.
    logic [7:0]     hue_reg, tri_reg, grad_reg, idx1_reg;
    logic [NW+7:0]  head_prod_reg;
    logic [14:0]    tri95_reg;
    logic [NW-1:0]  pmod_reg;
    logic           black1_reg;
    logic [7:0]     ph, tri_next;

    always_comb
    begin
        ph       = zone_cfg.speed_zero ? 8'd0 : ph_raw;
        tri_next = tri_wave(ph);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            hue_reg       <= ph + hue_off;
            tri_reg       <= tri_next;
            tri95_reg     <= 15'(tri_next) * 15'd95;
            grad_reg      <= zone_cfg.n_is_one ? LEVEL_FULL : ph + grad_off;
            head_prod_reg <= (NW+8)'(ph) * (NW+8)'(n);
            pmod_reg      <= pmod;
            idx1_reg      <= idx;
            black1_reg    <= black;
        end
    end

    // Second stage: pick the channel sources and the level.
    logic [7:0]    cr_reg, cg_reg, cb_reg, lvl_reg, idx2_reg;
    logic          black2_reg;
    logic [NW-1:0] head, tail_dist;
    logic [NW:0]   dsum;
    logic [7:0]    snake_lvl, hue_a, hue3, wr, wg, wb, lvl_next;
    logic [7:0]    cr_next, cg_next, cb_next;

    always_comb
    begin
        head = head_prod_reg[NW+7:8];
        dsum = {1'b0, head} + {1'b0, n} - {1'b0, pmod_reg};
        tail_dist = (dsum >= {1'b0, n}) ? NW'(dsum - {1'b0, n}) : NW'(dsum);
        if (tail_dist == NW'(0))
        begin
            snake_lvl = 8'd255;
        end
        else if (tail_dist == NW'(1))
        begin
            snake_lvl = 8'd128;
        end
        else if (tail_dist == NW'(2))
        begin
            snake_lvl = 8'd64;
        end
        else
        begin
            snake_lvl = 8'd0;
        end

        if (hue_reg < 8'd85)
        begin
            hue_a = hue_reg;
        end
        else if (hue_reg < 8'd170)
        begin
            hue_a = hue_reg - 8'd85;
        end
        else
        begin
            hue_a = hue_reg - 8'd170;
        end
        hue3 = 8'(10'(hue_a) * 10'd3);
        if (hue_reg < 8'd85)
        begin
            wr = 8'd255 - hue3;
            wg = hue3;
            wb = 8'd0;
        end
        else if (hue_reg < 8'd170)
        begin
            wr = 8'd0;
            wg = 8'd255 - hue3;
            wb = hue3;
        end
        else
        begin
            wr = hue3;
            wg = 8'd0;
            wb = 8'd255 - hue3;
        end

        cr_next = zone_cfg.base[23:16];
        cg_next = zone_cfg.base[15:8];
        cb_next = zone_cfg.base[7:0];
        case (zone_cfg.mode)
            MODE_SNAKE:    lvl_next = snake_lvl;
            MODE_BREATH:   lvl_next = tri_reg;
            MODE_GRADIENT: lvl_next = grad_reg;
            MODE_SHALLOW:  lvl_next = 8'd160 + div255(16'(tri95_reg));
            MODE_RAINBOW:
            begin
                lvl_next = LEVEL_FULL;
                cr_next  = wr;
                cg_next  = wg;
                cb_next  = wb;
            end
            default:       lvl_next = LEVEL_FULL;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            cr_reg     <= cr_next;
            cg_reg     <= cg_next;
            cb_reg     <= cb_next;
            lvl_reg    <= lvl_next;
            idx2_reg   <= idx1_reg;
            black2_reg <= black1_reg;
        end
    end

    // Third stage: scale by level; fourth stage: scale by brightness.
    logic [7:0] er_reg, eg_reg, eb_reg, idx3_reg;
    logic       black3_reg;
    logic [7:0] or_reg, og_reg, ob_reg, idx4_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            er_reg     <= div255(16'(cr_reg) * 16'(lvl_reg) + 16'd127);
            eg_reg     <= div255(16'(cg_reg) * 16'(lvl_reg) + 16'd127);
            eb_reg     <= div255(16'(cb_reg) * 16'(lvl_reg) + 16'd127);
            idx3_reg   <= idx2_reg;
            black3_reg <= black2_reg;
        end
        if (load[3])
        begin
            or_reg   <= black3_reg ? 8'd0
                        : div255(16'(er_reg) * 16'(zone_cfg.bright) + 16'd127);
            og_reg   <= black3_reg ? 8'd0
                        : div255(16'(eg_reg) * 16'(zone_cfg.bright) + 16'd127);
            ob_reg   <= black3_reg ? 8'd0
                        : div255(16'(eb_reg) * 16'(zone_cfg.bright) + 16'd127);
            idx4_reg <= idx3_reg;
        end
    end

    assign led_index_out = idx4_reg;
    assign red           = or_reg;
    assign green         = og_reg;
    assign blue          = ob_reg;

endmodule

[design/led_effect_pixel_renderer.sv]
// Channel   Role    Payload
// pixel     sink    time_ms[47:0], position[7:0], led_index[7:0], enable
// color     source  led_index_out[7:0], red[7:0], green[7:0], blue[7:0]
// cfg       sink    index[2:0], data[23:0]
//
// One pixel enters per cycle unless output backpressure has filled every stage; each result
// passes through the 14-stage phase divider (four dividend bits per stage) and then four
// shading stages before it is valid at the output.
// Every stage holds its own valid bit, so bubbles close up under output backpressure.
// Configuration is taken every cycle; derived values are ready at the next edge.
// Reset clears the valid bits and sets the configuration registers to their defaults.
module led_effect_pixel_renderer
    import lep_pkg::*;
#(
    parameter int MAX_PIXELS = 256
)
(
    input  logic      clk,
    input  logic      rst_n,
    lep_pix_if.sink   pixel,
    lep_rgb_if.source color,
    lep_cfg_if.sink   cfg
);

    localparam int NW = $clog2(MAX_PIXELS + 1);
    localparam int NS = DIV_STAGES + SHADE_STAGES;
    localparam int PH_DW  = DIV_STAGES * PHASE_SPS;
    localparam int HUE_DW = DIV_STAGES * HUE_SPS;
    localparam int MOD_DW = DIV_STAGES * MOD_SPS;

    lep_cfg_t      zone_cfg;
    logic [NW-1:0] n, n_minus1;

    lep_cfg #(.MAX_PIXELS(MAX_PIXELS), .NW(NW)) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .zone_cfg (zone_cfg),
        .n        (n),
        .n_minus1 (n_minus1)
    );

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;
    logic          in_fire;

    always_comb
    begin
        en[NS] = color.ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign pixel.ready = en[0];
    assign in_fire     = pixel.valid && en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= (i == 0) ? in_fire : v_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // Side data that rides along the divider stages.
    logic [7:0] idx_reg [DIV_STAGES];
    logic       black_reg [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            if (en[i])
            begin
                if (i == 0)
                begin
                    idx_reg[i]   <= pixel.led_index;
                    black_reg[i] <= !pixel.enable || (zone_cfg.mode == MODE_OFF);
                end
                else
                begin
                    idx_reg[i]   <= idx_reg[(i == 0) ? 0 : i - 1];
                    black_reg[i] <= black_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    logic [7:0]    ph_raw, hue_off, grad_off;
    logic [NW-1:0] pmod;
    logic [15:0]   grad_dvd;

    assign grad_dvd = {pixel.position, 8'd0} - 16'(pixel.position);

    // The low quotient byte of (t*256)/period is the phase of t within its period.
    lep_div #(.STAGES(DIV_STAGES), .SPS(PHASE_SPS), .DVW(12), .QW(8)) u_phase (
        .clk       (clk),
        .load      (en[DIV_STAGES-1:0]),
        .dividend  (PH_DW'({pixel.time_ms, 8'd0})),
        .divisor   (zone_cfg.period),
        .quotient  (ph_raw),
        .remainder ()
    );

    lep_div #(.STAGES(DIV_STAGES), .SPS(HUE_SPS), .DVW(NW), .QW(8)) u_hue (
        .clk       (clk),
        .load      (en[DIV_STAGES-1:0]),
        .dividend  (HUE_DW'({pixel.position, 8'd0})),
        .divisor   (n),
        .quotient  (hue_off),
        .remainder ()
    );

    lep_div #(.STAGES(DIV_STAGES), .SPS(HUE_SPS), .DVW(NW), .QW(8)) u_grad (
        .clk       (clk),
        .load      (en[DIV_STAGES-1:0]),
        .dividend  (HUE_DW'(grad_dvd)),
        .divisor   (n_minus1),
        .quotient  (grad_off),
        .remainder ()
    );

    lep_div #(.STAGES(DIV_STAGES), .SPS(MOD_SPS), .DVW(NW), .QW(1)) u_mod (
        .clk       (clk),
        .load      (en[DIV_STAGES-1:0]),
        .dividend  (MOD_DW'(pixel.position)),
        .divisor   (n),
        .quotient  (),
        .remainder (pmod)
    );

    lep_shade #(.NW(NW)) u_shade (
        .clk           (clk),
        .load          (en[NS-1:DIV_STAGES]),
        .zone_cfg      (zone_cfg),
        .n             (n),
        .ph_raw        (ph_raw),
        .hue_off       (hue_off),
        .grad_off      (grad_off),
        .pmod          (pmod),
        .idx           (idx_reg[DIV_STAGES-1]),
        .black         (black_reg[DIV_STAGES-1]),
        .led_index_out (color.led_index_out),
        .red           (color.red),
        .green         (color.green),
        .blue          (color.blue)
    );

    assign color.valid = v_reg[NS-1];

    // Input is refused only when the output holds a result that is not taken.
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> (color.valid && !color.ready))
        else $error("input refused without output backpressure");

    a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
        (zone_cfg.period >= 12'd1000) && (zone_cfg.period <= PERIOD_SLOW))
        else $error("animation period out of range");

    a_mod_below_zone: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[DIV_STAGES-1] |-> (pmod < n))
        else $error("position remainder not below zone size");

    a_zone_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (n != '0) && (n_minus1 == n - NW'(1)))
        else $error("zone size registers inconsistent");

endmodule
